// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// types, codes and saturation helper of the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qau_pkg;

   typedef enum logic [1:0] {
      KIND_MUL  = 2'd0,
      KIND_ROT  = 2'd1,
      KIND_NORM = 2'd2,
      KIND_CONJ = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] a_s;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_s;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
   } quat_req_type;

   typedef struct packed {
      logic signed [31:0] r_s;
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic               degenerate;
      logic               saturated;
   } quat_rsp_type;

   localparam int PROD_W     = 64;
   localparam int SUM_W      = 68;
   localparam int SQRT_STEPS = 32;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

   // returns {clip, value}
   function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [32:0] r;
      if (v > SAT_MAX) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < SAT_MIN) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] ext32(input logic signed [31:0] x);
      return {{(SUM_W-32){x[31]}}, x};
   endfunction

endpackage

// ===== hdl/quaternion_arith_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// fixed-point quaternion product, vector rotation, normalize and conjugate
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  request   start, busy, req_item    beat when start and not busy
//  response  rsp_strobe, rsp_item     one-cycle strobe, always taken
//
//  every kind runs through every stage, with Q16.16 at the default FRAC_BITS; one beat
//  per cycle in and out; the restoring divider, one quotient bit per stage,
//  and the 32-stage square root set the depth.
//  busy stays low: every stage advances each cycle and results leave in order.
//  reset clears only the valid bits.
`include "assert_macros.svh"

module quaternion_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  qau_pkg::quat_req_type req_item,
   output logic                  rsp_strobe,
   output qau_pkg::quat_rsp_type rsp_item
);

   localparam int PW = qau_pkg::PROD_W;
   localparam int SW = qau_pkg::SUM_W;
   localparam int SQ = qau_pkg::SQRT_STEPS;
   localparam int NW = 33 + FRAC_BITS;
   localparam logic signed [PW-1:0] HALF  = PW'(64'sd1) <<< (FRAC_BITS - 1);
   localparam logic [31:0]          ONE_Q = 32'd1 << FRAC_BITS;

   typedef struct packed {
      qau_pkg::kind_type kind;
      logic [3:0][31:0]  res;
      logic              clip;
      logic [3:0][31:0]  a;
      logic [2:0][31:0]  b;
      logic [2:0][31:0]  u;
      logic              u_clip;
      logic [63:0]       sum;
      logic              carry;
      logic              zero;
   } mid_type;

   typedef struct packed {
      qau_pkg::kind_type kind;
      logic [3:0][31:0]  res;
      logic              clip;
      logic [3:0][31:0]  a;
      logic              carry;
      logic              zero;
   } pass_type;

   function automatic logic signed [PW-1:0] mul32(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
      logic signed [PW-1:0] p;
      p = x * y;
      return p;
   endfunction

   function automatic logic signed [SW-1:0] rnd(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = (p + HALF) >>> FRAC_BITS;
      return {{(SW-PW){t[PW-1]}}, t};
   endfunction

   assign busy = 1'b0;

   // stage 1: input register
   logic                  s1_valid_ff;
   qau_pkg::quat_req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_req_ff <= req_item;
   end

   // stage 2: raw products, shared by multiply and the first cross product
   logic signed [PW-1:0]  s2_prod_in [16];
   logic signed [PW-1:0]  s2_prod_ff [16];
   logic signed [PW-1:0]  s2_sq_in [4];
   logic signed [PW-1:0]  s2_sq_ff [4];
   logic                  s2_valid_ff;
   qau_pkg::quat_req_type s2_req_ff;

   always_comb begin
      s2_prod_in[0]  = mul32(s1_req_ff.a_s, s1_req_ff.b_s);
      s2_prod_in[1]  = mul32(s1_req_ff.a_x, s1_req_ff.b_x);
      s2_prod_in[2]  = mul32(s1_req_ff.a_y, s1_req_ff.b_y);
      s2_prod_in[3]  = mul32(s1_req_ff.a_z, s1_req_ff.b_z);
      s2_prod_in[4]  = mul32(s1_req_ff.a_s, s1_req_ff.b_x);
      s2_prod_in[5]  = mul32(s1_req_ff.b_s, s1_req_ff.a_x);
      s2_prod_in[6]  = mul32(s1_req_ff.a_y, s1_req_ff.b_z);
      s2_prod_in[7]  = mul32(s1_req_ff.a_z, s1_req_ff.b_y);
      s2_prod_in[8]  = mul32(s1_req_ff.a_s, s1_req_ff.b_y);
      s2_prod_in[9]  = mul32(s1_req_ff.b_s, s1_req_ff.a_y);
      s2_prod_in[10] = mul32(s1_req_ff.a_z, s1_req_ff.b_x);
      s2_prod_in[11] = mul32(s1_req_ff.a_x, s1_req_ff.b_z);
      s2_prod_in[12] = mul32(s1_req_ff.a_s, s1_req_ff.b_z);
      s2_prod_in[13] = mul32(s1_req_ff.b_s, s1_req_ff.a_z);
      s2_prod_in[14] = mul32(s1_req_ff.a_x, s1_req_ff.b_y);
      s2_prod_in[15] = mul32(s1_req_ff.a_y, s1_req_ff.b_x);
      s2_sq_in[0]    = mul32(s1_req_ff.a_s, s1_req_ff.a_s);
      s2_sq_in[1]    = mul32(s1_req_ff.a_x, s1_req_ff.a_x);
      s2_sq_in[2]    = mul32(s1_req_ff.a_y, s1_req_ff.a_y);
      s2_sq_in[3]    = mul32(s1_req_ff.a_z, s1_req_ff.a_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_prod_ff <= s2_prod_in;
      s2_sq_ff   <= s2_sq_in;
      s2_req_ff  <= s1_req_ff;
   end

   // stage 3: rounding, product sums, first cross product, conjugate, sum of squares
   logic signed [SW-1:0] rp [16];
   logic signed [SW-1:0] mul_r [4];
   logic [32:0]          mul_s [4];
   logic [32:0]          conj_s [3];
   logic [32:0]          u_s [3];
   logic [65:0]          sq_sum;
   mid_type              s3_in;
   mid_type              s3_ff;
   logic                 s3_valid_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         rp[i] = rnd(s2_prod_ff[i]);
      end
      mul_r[0] = rp[0] - rp[1] - rp[2] - rp[3];
      mul_r[1] = rp[4] + rp[5] + rp[6] - rp[7];
      mul_r[2] = rp[8] + rp[9] + rp[10] - rp[11];
      mul_r[3] = rp[12] + rp[13] + rp[14] - rp[15];
      for (int i = 0; i < 4; i++) begin
         mul_s[i] = qau_pkg::sat32(mul_r[i]);
      end
      u_s[0] = qau_pkg::sat32(rp[6] - rp[7]);
      u_s[1] = qau_pkg::sat32(rp[10] - rp[11]);
      u_s[2] = qau_pkg::sat32(rp[14] - rp[15]);
      conj_s[0] = qau_pkg::sat32(-qau_pkg::ext32(s2_req_ff.a_x));
      conj_s[1] = qau_pkg::sat32(-qau_pkg::ext32(s2_req_ff.a_y));
      conj_s[2] = qau_pkg::sat32(-qau_pkg::ext32(s2_req_ff.a_z));
      sq_sum = {2'b00, s2_sq_ff[0]} + {2'b00, s2_sq_ff[1]}
             + {2'b00, s2_sq_ff[2]} + {2'b00, s2_sq_ff[3]};

      s3_in.kind = s2_req_ff.kind;
      if (s2_req_ff.kind == qau_pkg::KIND_CONJ) begin
         s3_in.res  = {conj_s[2][31:0], conj_s[1][31:0], conj_s[0][31:0], s2_req_ff.a_s};
         s3_in.clip = conj_s[0][32] | conj_s[1][32] | conj_s[2][32];
      end else begin
         s3_in.res  = {mul_s[3][31:0], mul_s[2][31:0], mul_s[1][31:0], mul_s[0][31:0]};
         s3_in.clip = mul_s[0][32] | mul_s[1][32] | mul_s[2][32] | mul_s[3][32];
      end
      s3_in.a      = {s2_req_ff.a_z, s2_req_ff.a_y, s2_req_ff.a_x, s2_req_ff.a_s};
      s3_in.b      = {s2_req_ff.b_z, s2_req_ff.b_y, s2_req_ff.b_x};
      s3_in.u      = {u_s[2][31:0], u_s[1][31:0], u_s[0][31:0]};
      s3_in.u_clip = u_s[0][32] | u_s[1][32] | u_s[2][32];
      s3_in.sum    = sq_sum[63:0];
      s3_in.carry  = |sq_sum[65:64];
      s3_in.zero   = (s2_req_ff.a_s == 32'sd0) && (s2_req_ff.a_x == 32'sd0)
                  && (s2_req_ff.a_y == 32'sd0) && (s2_req_ff.a_z == 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_ff <= s3_in;
   end

   // stage 4: products of the second cross product and of the scalar
   logic signed [PW-1:0] s4_prod_in [9];
   logic signed [PW-1:0] s4_prod_ff [9];
   mid_type              s4_ff;
   logic                 s4_valid_ff;

   always_comb begin
      s4_prod_in[0] = mul32(s3_ff.a[0], s3_ff.u[0]);
      s4_prod_in[1] = mul32(s3_ff.a[0], s3_ff.u[1]);
      s4_prod_in[2] = mul32(s3_ff.a[0], s3_ff.u[2]);
      s4_prod_in[3] = mul32(s3_ff.a[2], s3_ff.u[2]);
      s4_prod_in[4] = mul32(s3_ff.a[3], s3_ff.u[1]);
      s4_prod_in[5] = mul32(s3_ff.a[3], s3_ff.u[0]);
      s4_prod_in[6] = mul32(s3_ff.a[1], s3_ff.u[2]);
      s4_prod_in[7] = mul32(s3_ff.a[1], s3_ff.u[1]);
      s4_prod_in[8] = mul32(s3_ff.a[2], s3_ff.u[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_prod_ff <= s4_prod_in;
      s4_ff      <= s3_ff;
   end

   // stage 5: rotation result, then the square root pipeline takes over
   logic signed [SW-1:0] rq [9];
   logic [32:0]          w_s [3];
   logic [32:0]          rot_s [3];
   logic signed [SW-1:0] rot_r [3];
   pass_type             s5_in;

   logic                 sq_valid_ff [SQ+1];
   pass_type             sq_pass_ff [SQ+1];
   logic [63:0]          sq_rem_ff [SQ+1];
   logic [63:0]          sq_root_ff [SQ+1];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rq[i] = rnd(s4_prod_ff[i]);
      end
      w_s[0] = qau_pkg::sat32(rq[3] - rq[4]);
      w_s[1] = qau_pkg::sat32(rq[5] - rq[6]);
      w_s[2] = qau_pkg::sat32(rq[7] - rq[8]);
      for (int i = 0; i < 3; i++) begin
         rot_r[i] = qau_pkg::ext32(s4_ff.b[i])
                  + ((rq[i] + qau_pkg::ext32(w_s[i][31:0])) <<< 1);
         rot_s[i] = qau_pkg::sat32(rot_r[i]);
      end
      s5_in.kind  = s4_ff.kind;
      s5_in.a     = s4_ff.a;
      s5_in.carry = s4_ff.carry;
      s5_in.zero  = s4_ff.zero;
      if (s4_ff.kind == qau_pkg::KIND_ROT) begin
         s5_in.res  = {rot_s[2][31:0], rot_s[1][31:0], rot_s[0][31:0], 32'd0};
         s5_in.clip = s4_ff.u_clip | w_s[0][32] | w_s[1][32] | w_s[2][32]
                    | rot_s[0][32] | rot_s[1][32] | rot_s[2][32];
      end else begin
         s5_in.res  = s4_ff.res;
         s5_in.clip = s4_ff.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= s4_valid_ff;
      end
      sq_pass_ff[0] <= s5_in;
      sq_rem_ff[0]  <= s4_ff.sum;
      sq_root_ff[0] <= 64'd0;
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [64:0] trial;
      logic [63:0] rem_in;
      logic [63:0] root_in;

      always_comb begin
         trial = {1'b0, sq_root_ff[k]} + {1'b0, BIT};
         if ({1'b0, sq_rem_ff[k]} >= trial) begin
            rem_in  = sq_rem_ff[k] - trial[63:0];
            root_in = (sq_root_ff[k] >> 1) + BIT;
         end else begin
            rem_in  = sq_rem_ff[k];
            root_in = sq_root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         sq_pass_ff[k+1] <= sq_pass_ff[k];
         sq_rem_ff[k+1]  <= rem_in;
         sq_root_ff[k+1] <= root_in;
      end
   end

   // divider setup: magnitude and rounded numerator per lane
   logic                    dv_valid_ff [NW+1];
   pass_type                dv_pass_ff [NW+1];
   logic [32:0]             dv_m_ff [NW+1];
   logic [3:0][32:0]        dv_rem_ff [NW+1];
   logic [3:0][NW-1:0]      dv_rq_ff [NW+1];
   logic [32:0]             m_in;
   logic [3:0][NW-1:0]      num_in;
   logic [31:0]             mag;

   always_comb begin
      m_in = sq_pass_ff[SQ].carry ? {1'b1, 32'd0} : sq_root_ff[SQ][32:0];
      mag  = 32'd0;
      for (int i = 0; i < 4; i++) begin
         mag = sq_pass_ff[SQ].a[i][31] ? -sq_pass_ff[SQ].a[i] : sq_pass_ff[SQ].a[i];
         num_in[i] = {1'b0, mag, {FRAC_BITS{1'b0}}} + {{(NW-33){1'b0}}, 1'b0, m_in[32:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= sq_valid_ff[SQ];
      end
      dv_pass_ff[0] <= sq_pass_ff[SQ];
      dv_m_ff[0]    <= m_in;
      dv_rem_ff[0]  <= '0;
      dv_rq_ff[0]   <= num_in;
   end

   // restoring division, one quotient bit per stage, four lanes
   for (genvar j = 0; j < NW; j++) begin : g_div
      logic [3:0][32:0]   rem_in;
      logic [3:0][NW-1:0] rq_in;
      logic [33:0]        trial;

      always_comb begin
         trial = '0;
         for (int i = 0; i < 4; i++) begin
            trial = {dv_rem_ff[j][i], dv_rq_ff[j][i][NW-1]};
            if (trial >= {1'b0, dv_m_ff[j]}) begin
               rem_in[i] = 33'(trial - {1'b0, dv_m_ff[j]});
               rq_in[i]  = {dv_rq_ff[j][i][NW-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[32:0];
               rq_in[i]  = {dv_rq_ff[j][i][NW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         dv_pass_ff[j+1] <= dv_pass_ff[j];
         dv_m_ff[j+1]    <= dv_m_ff[j];
         dv_rem_ff[j+1]  <= rem_in;
         dv_rq_ff[j+1]   <= rq_in;
      end
   end

   // output select and response register
   logic signed [SW-1:0]  nq;
   logic [3:0][32:0]      norm_s;
   pass_type              fin;
   qau_pkg::quat_rsp_type rsp_in;
   qau_pkg::quat_rsp_type rsp_item_ff;
   logic                  rsp_strobe_ff;
   logic                  rsp_ident;

   always_comb begin
      fin = dv_pass_ff[NW];
      nq  = '0;
      for (int i = 0; i < 4; i++) begin
         nq = {{(SW-NW){1'b0}}, dv_rq_ff[NW][i]};
         if (fin.a[i][31]) begin
            nq = -nq;
         end
         norm_s[i] = qau_pkg::sat32(nq);
      end
      rsp_in.degenerate = 1'b0;
      if (fin.kind == qau_pkg::KIND_NORM && fin.zero) begin
         rsp_in.r_s        = ONE_Q;
         rsp_in.r_x        = 32'sd0;
         rsp_in.r_y        = 32'sd0;
         rsp_in.r_z        = 32'sd0;
         rsp_in.degenerate = 1'b1;
         rsp_in.saturated  = 1'b0;
      end else if (fin.kind == qau_pkg::KIND_NORM) begin
         rsp_in.r_s       = norm_s[0][31:0];
         rsp_in.r_x       = norm_s[1][31:0];
         rsp_in.r_y       = norm_s[2][31:0];
         rsp_in.r_z       = norm_s[3][31:0];
         rsp_in.saturated = norm_s[0][32] | norm_s[1][32] | norm_s[2][32] | norm_s[3][32];
      end else begin
         rsp_in.r_s       = fin.res[0];
         rsp_in.r_x       = fin.res[1];
         rsp_in.r_y       = fin.res[2];
         rsp_in.r_z       = fin.res[3];
         rsp_in.saturated = fin.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid_ff[NW];
      end
      rsp_item_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // scalar of one, zero x part and no clip flag; y and z are not checked
   assign rsp_ident = rsp_item.r_s == ONE_Q && rsp_item.r_x == 32'sd0
                   && !rsp_item.saturated;

   `ASSERT_NEXT(a_beat_enters, start && !busy, s1_valid_ff)
   `ASSERT_NEXT(a_pipe_to_strobe, dv_valid_ff[NW], rsp_strobe)
   `ASSERT_IMPLIES(a_strobe_source, rsp_strobe, $past(dv_valid_ff[NW]))
   `ASSERT_IMPLIES(a_root_bound, sq_valid_ff[SQ], sq_root_ff[SQ][63:33] == 31'd0)
   `ASSERT_IMPLIES(a_degen_identity, rsp_strobe && rsp_item.degenerate, rsp_ident)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// quaternion unit check: directed and random beats against a fixed-point
// predictor; results are compared in order, field by field
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC      = 16;
   localparam int LIMIT     = 400000;
   localparam int DRAIN     = 200;
   localparam int N_RANDOM  = 1430;

   class quat_scoreboard;
      qau_pkg::quat_rsp_type expected_q[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function longint fx_mul(longint a, longint b);
         longint p;
         p = a * b + (longint'(1) <<< (FRAC - 1));
         return p >>> FRAC;
      endfunction

      function longint clip32(longint v, ref bit clip);
         if (v > 64'sd2147483647) begin
            clip = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            clip = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] n);
         logic [63:0] rem, res, bt;
         rem = n;
         res = 0;
         bt = 64'd1 << 62;
         while (bt > n) bt = bt >> 2;
         while (bt != 0) begin
            if (rem >= res + bt) begin
               rem = rem - (res + bt);
               res = (res >> 1) + bt;
            end else begin
               res = res >> 1;
            end
            bt = bt >> 2;
         end
         return res;
      endfunction

      function longint unit_comp(longint a, logic [63:0] m);
         logic [63:0] mag, q;
         mag = (a < 0) ? -a : a;
         q = ((mag << FRAC) + (m >> 1)) / m;
         return (a < 0) ? -longint'(q) : longint'(q);
      endfunction

      function qau_pkg::quat_rsp_type predict(qau_pkg::quat_req_type q);
         qau_pkg::quat_rsp_type rsp;
         longint as, ax, ay, az, bs, bx, by, bz, ux, uy, uz, wx, wy, wz;
         longint r[4];
         logic [65:0] sumsq;
         logic [63:0] m;
         bit clip;
         clip = 0;
         as = q.a_s; ax = q.a_x; ay = q.a_y; az = q.a_z;
         bs = q.b_s; bx = q.b_x; by = q.b_y; bz = q.b_z;
         r[0] = 0; r[1] = 0; r[2] = 0; r[3] = 0;
         rsp.degenerate = 0;
         case (q.kind)
            qau_pkg::KIND_MUL: begin
               r[0] = fx_mul(as, bs) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz);
               r[1] = fx_mul(as, bx) + fx_mul(bs, ax) + fx_mul(ay, bz) - fx_mul(az, by);
               r[2] = fx_mul(as, by) + fx_mul(bs, ay) + fx_mul(az, bx) - fx_mul(ax, bz);
               r[3] = fx_mul(as, bz) + fx_mul(bs, az) + fx_mul(ax, by) - fx_mul(ay, bx);
            end
            qau_pkg::KIND_ROT: begin
               ux = clip32(fx_mul(ay, bz) - fx_mul(az, by), clip);
               uy = clip32(fx_mul(az, bx) - fx_mul(ax, bz), clip);
               uz = clip32(fx_mul(ax, by) - fx_mul(ay, bx), clip);
               wx = clip32(fx_mul(ay, uz) - fx_mul(az, uy), clip);
               wy = clip32(fx_mul(az, ux) - fx_mul(ax, uz), clip);
               wz = clip32(fx_mul(ax, uy) - fx_mul(ay, ux), clip);
               r[1] = bx + 2 * (fx_mul(as, ux) + wx);
               r[2] = by + 2 * (fx_mul(as, uy) + wy);
               r[3] = bz + 2 * (fx_mul(as, uz) + wz);
            end
            qau_pkg::KIND_NORM: begin
               if (as == 0 && ax == 0 && ay == 0 && az == 0) begin
                  rsp.degenerate = 1;
                  r[0] = longint'(1) <<< FRAC;
               end else begin
                  sumsq = 66'(as * as) + 66'(ax * ax) + 66'(ay * ay) + 66'(az * az);
                  // sum past 64 bits takes the largest magnitude
                  m = (sumsq[65:64] != 0) ? (64'd1 << 32) : int_sqrt(sumsq[63:0]);
                  r[0] = unit_comp(as, m);
                  r[1] = unit_comp(ax, m);
                  r[2] = unit_comp(ay, m);
                  r[3] = unit_comp(az, m);
               end
            end
            default: begin
               r[0] = as; r[1] = -ax; r[2] = -ay; r[3] = -az;
            end
         endcase
         rsp.r_s = 32'(clip32(r[0], clip));
         rsp.r_x = 32'(clip32(r[1], clip));
         rsp.r_y = 32'(clip32(r[2], clip));
         rsp.r_z = 32'(clip32(r[3], clip));
         rsp.saturated = clip;
         return rsp;
      endfunction

      function void note_beat(qau_pkg::quat_req_type q);
         expected_q.push_back(predict(q));
      endfunction

      function void check_result(qau_pkg::quat_rsp_type got);
         qau_pkg::quat_rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.r_s !== exp_rsp.r_s) begin
            $error("r_s expected %h got %h", exp_rsp.r_s, got.r_s); errors++;
         end
         if (got.r_x !== exp_rsp.r_x) begin
            $error("r_x expected %h got %h", exp_rsp.r_x, got.r_x); errors++;
         end
         if (got.r_y !== exp_rsp.r_y) begin
            $error("r_y expected %h got %h", exp_rsp.r_y, got.r_y); errors++;
         end
         if (got.r_z !== exp_rsp.r_z) begin
            $error("r_z expected %h got %h", exp_rsp.r_z, got.r_z); errors++;
         end
         if (got.degenerate !== exp_rsp.degenerate) begin
            $error("degenerate expected %b got %b", exp_rsp.degenerate, got.degenerate);
            errors++;
         end
         if (got.saturated !== exp_rsp.saturated) begin
            $error("saturated expected %b got %b", exp_rsp.saturated, got.saturated);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   qau_pkg::quat_req_type req_item = '0;
   logic                  rsp_strobe;
   qau_pkg::quat_rsp_type rsp_item;
   int                    cycle_count = 0;
   quat_scoreboard        sb;

   quaternion_arith_unit #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial sb = new();

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) sb.note_beat(req_item);
         if (rsp_strobe) sb.check_result(rsp_item);
      end
   end

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 5))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 0;
               3: return -1;
               4: return 1;
               default: return 32'sh0001_0000;
            endcase
         end
         1, 2, 3, 4: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         5, 6: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: return $signed($urandom);
      endcase
   endfunction

   // one beat; start stays high from beat to beat unless a gap is taken
   task automatic send_beat(qau_pkg::quat_req_type q, bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 99) < 14) begin
         gap = $urandom_range(1, 6);
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_item <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_quat(qau_pkg::kind_type k, logic signed [31:0] s0, x0, y0, z0,
                            logic signed [31:0] s1, x1, y1, z1);
      qau_pkg::quat_req_type q;
      q.kind = k;
      q.a_s = s0; q.a_x = x0; q.a_y = y0; q.a_z = z0;
      q.b_s = s1; q.b_x = x1; q.b_y = y1; q.b_z = z1;
      send_beat(q, 1);
   endtask

   initial begin
      qau_pkg::quat_req_type q;
      logic signed [31:0] mx, mn, one;
      bit gaps;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      one = 32'sh0001_0000;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send_quat(qau_pkg::KIND_MUL, one, 0, 0, 0, one, one, one, one);
      send_quat(qau_pkg::KIND_MUL, mx, mx, mx, mx, mx, mx, mx, mx);
      send_quat(qau_pkg::KIND_MUL, mn, mn, mn, mn, mn, mn, mn, mn);
      send_quat(qau_pkg::KIND_MUL, mx, mn, mx, mn, mn, mx, mn, mx);
      send_quat(qau_pkg::KIND_MUL, 32'sh8000, -32'sh8000, 1, -1, 1, 1, -1, -1);
      send_quat(qau_pkg::KIND_ROT, one, 0, 0, 0, 0, one, 2 * one, 3 * one);
      send_quat(qau_pkg::KIND_ROT, 32'sh0000_B505, 0, 0, 32'sh0000_B505, 0, one, 0, 0);
      send_quat(qau_pkg::KIND_ROT, mx, mx, mn, mx, 0, mn, mx, mn);
      send_quat(qau_pkg::KIND_ROT, mn, mn, mn, mn, mx, mx, mx, mx);
      send_quat(qau_pkg::KIND_NORM, 0, 0, 0, 0, mx, mx, mx, mx);
      send_quat(qau_pkg::KIND_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_NORM, 0, 0, 0, -1, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_NORM, mn, mn, mn, mn, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_NORM, mx, mx, mx, mx, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_NORM, mn, 0, 0, 0, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_NORM, 3 * one, 4 * one, 0, 0, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_CONJ, mx, mn, mx, 0, mn, mn, mn, mn);
      send_quat(qau_pkg::KIND_CONJ, mn, mx, mn, -1, 0, 0, 0, 0);
      send_quat(qau_pkg::KIND_CONJ, one, one, -one, 0, 0, 0, 0, 0);

      // drain once with the sender held off
      start <= 0;
      while (sb.pending() != 0) @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         q.kind = qau_pkg::kind_type'($urandom_range(0, 3));
         q.a_s = pick_value(); q.a_x = pick_value();
         q.a_y = pick_value(); q.a_z = pick_value();
         q.b_s = pick_value(); q.b_x = pick_value();
         q.b_y = pick_value(); q.b_z = pick_value();
         // zero quaternion now and then so the degenerate path sees gaps too
         if ($urandom_range(0, 19) == 0) begin
            q.a_s = 0; q.a_x = 0; q.a_y = 0; q.a_z = 0;
         end
         gaps = !(i >= 500 && i < 800);
         send_beat(q, gaps);
      end
      start <= 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/qau_pkg.sv
hdl/quaternion_arith_unit.sv
tb/tb_top.sv
